>>> sv/sbt_pkg.sv
package sbt_pkg;

   localparam int NUM_ENTRIES_DEF = 128;
   localparam int ADDR_W = 32;
   localparam int WORD_W = 16;
   localparam int SLOT_W = 7;
   localparam int STATUS_W = 2;
   localparam int CMD_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [WORD_W-1:0] TRAP_OPCODE = 16'h4e40;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_BAD_ADDR  = 2'd1,
      STS_FULL      = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_START = 1'd0,
      CSR_BSS_END    = 1'd1
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [WORD_W-1:0] saved_word;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic vld_clr;
      logic clear_all;
   } store_ctl_type;

endpackage

>>> sv/software_breakpoint_table.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  command, address, original_word
// rsp       out        rsp_valid/rsp_stall  status, slot_index, write_back, word_out
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// clear and a rejected insert go straight to the done state; other commands scan the table
// one slot a cycle through the entry memory read port, until a hit or the last slot
// reset empties the table and sets both address bounds to zero
// req_stall is high from the transfer until the result is loaded into the output register
// a stalled result holds; the next command is taken while it waits

module software_breakpoint_table
   import sbt_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [WORD_W-1:0]     req_original_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic                  rsp_write_back,
   output logic [WORD_W-1:0]     rsp_word_out,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_ENTRIES);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] text_start_ff, bss_end_ff;

   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] word_ff, word_in;

   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             cmp_act_ff, cmp_act_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   status_type        res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              res_wb_ff, res_wb_in;
   logic [WORD_W-1:0] res_word_ff, res_word_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_wb_ff, rsp_wb_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;

   store_ctl_type st_ctl;
   entry_type     rd_entry;
   logic          rd_valid;

   logic                   accept, bad_addr, issue, hit, last, out_free;
   cmd_type                req_cmd;
   logic [IDX_W+SLOT_W-1:0] slot_wide;

   sbt_store #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (st_ctl),
      .wr_idx   (cmp_idx_ff),
      .wr_entry ({addr_ff, word_ff}),
      .rd_idx   (scan_cnt_ff[IDX_W-1:0]),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_cmd   = cmd_type'(req_command);
   assign bad_addr  = req_address[0] || (req_address < text_start_ff)
                      || (req_address > bss_end_ff);
   assign issue     = (scan_cnt_ff < CNT_END);
   assign hit       = cmp_act_ff && ((cmd_ff == CMD_INSERT) ? !rd_valid
                      : (rd_valid && (rd_entry.address == addr_ff)));
   assign last      = cmp_act_ff && (cmp_idx_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_wide = {{SLOT_W{1'b0}}, cmp_idx_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CLEAR || (req_cmd == CMD_INSERT && bad_addr)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit || last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      word_in       = word_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_act_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_wb_in     = res_wb_ff;
      res_word_in   = res_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_wb_in     = rsp_wb_ff;
      rsp_word_in   = rsp_word_ff;
      st_ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd;
               addr_in       = req_address;
               word_in       = req_original_word;
               scan_cnt_in   = '0;
               res_status_in = (req_cmd == CMD_INSERT) ? STS_BAD_ADDR : STS_OK;
               res_slot_in   = '0;
               res_wb_in     = 1'b0;
               res_word_in   = '0;
               st_ctl.clear_all = (req_cmd == CMD_CLEAR);
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
            cmp_act_in = issue && !hit;
            cmp_idx_in = scan_cnt_ff[IDX_W-1:0];
            if (hit) begin
               res_status_in = STS_OK;
               res_slot_in   = slot_wide[SLOT_W-1:0];
               unique case (cmd_ff)
                  CMD_INSERT: begin
                     st_ctl.wr_en = 1'b1;
                     res_wb_in    = 1'b1;
                     res_word_in  = TRAP_OPCODE;
                  end
                  CMD_REMOVE: begin
                     st_ctl.vld_clr = 1'b1;
                     res_wb_in      = 1'b1;
                     res_word_in    = rd_entry.saved_word;
                  end
                  default: begin
                     res_wb_in   = 1'b0;
                     res_word_in = '0;
                  end
               endcase
            end else if (last) begin
               res_status_in = (cmd_ff == CMD_INSERT) ? STS_FULL : STS_NOT_FOUND;
               res_slot_in   = '0;
               res_wb_in     = 1'b0;
               res_word_in   = '0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_wb_in     = res_wb_ff;
               rsp_word_in   = res_word_ff;
            end
         end
         default: begin
            cmp_act_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_act_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_cnt_ff   <= '0;
         text_start_ff <= '0;
         bss_end_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_act_ff   <= cmp_act_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_cnt_ff  <= scan_cnt_in;
         if (csr_write_enable) begin
            unique case (csr_type'(csr_index))
               CSR_TEXT_START: text_start_ff <= csr_write_data;
               CSR_BSS_END:    bss_end_ff    <= csr_write_data;
               default:        bss_end_ff    <= bss_end_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      word_ff       <= word_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_wb_ff     <= res_wb_in;
      res_word_ff   <= res_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_wb_ff     <= rsp_wb_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_write_back = rsp_wb_ff;
   assign rsp_word_out   = rsp_word_ff;

   // failed commands carry no slot and no word
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STS_OK)
      |-> (rsp_slot_ff == '0) && !rsp_wb_ff && (rsp_word_ff == '0))
      else $error("failed result carries slot or word");

   a_wb_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wb_ff |-> (rsp_status_ff == STS_OK))
      else $error("write back without ok status");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_act_ff |-> (state_ff == ST_SCAN))
      else $error("compare stage active outside scan");

   a_write_insert: assert property (@(posedge clock) disable iff (reset)
      st_ctl.wr_en |-> (state_ff == ST_SCAN) && (cmd_ff == CMD_INSERT) && !rd_valid)
      else $error("table write outside insert on a free slot");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= CNT_END)
      else $error("scan counter past table end");

endmodule

>>> sv/sbt_store.sv
module sbt_store
   import sbt_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   parameter int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  store_ctl_type    ctl,
   input  logic [IDX_W-1:0] wr_idx,
   input  entry_type        wr_entry,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry,
   output logic             rd_valid
);

   logic      valid_ff [NUM_ENTRIES];
   entry_type mem_ff [NUM_ENTRIES];
   entry_type rd_entry_ff;
   logic      rd_valid_ff;

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (ctl.wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end else if (ctl.vld_clr) begin
         valid_ff[wr_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule
